@@ rtl/core/lzwbp_pkg.sv @@
// package for the lzw code bit packer
// shared constants and the queue entry type, no dependencies
package lzwbp_pkg;

   localparam int MAX_CODE_BITS = 16;
   localparam int VALUE_BITS    = 16;
   localparam int MIN_CODE_BITS = 9;
   localparam int BYTE_BITS     = 8;
   localparam int LEFT_BITS     = BYTE_BITS - 1;
   localparam int WIDTH_BITS    = 5;
   localparam int ACC_BITS      = LEFT_BITS + VALUE_BITS;
   localparam int CODE_BITS_LIM = (MAX_CODE_BITS < VALUE_BITS) ? MAX_CODE_BITS : VALUE_BITS;
   localparam int QUEUE_DEPTH   = 2;

   typedef struct packed {
      logic [BYTE_BITS-1:0] byte0;
      logic [BYTE_BITS-1:0] byte1;
      logic                 two;
   } pkt_type;

   typedef struct packed {
      logic    valid;
      pkt_type pkt;
   } head_type;

endpackage

@@ rtl/core/lzwbp_front.sv @@
// front part: takes codes, joins them to the leftover bits and forms the bytes
// depends on lzwbp_pkg
module lzwbp_front import lzwbp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [VALUE_BITS-1:0] req_code_value,
   input  logic [WIDTH_BITS-1:0] req_code_width,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_msb_first,
   input  logic                  q_full,
   output logic                  q_push,
   output pkt_type               q_pkt
);

   logic                  msb_first_ff, msb_first_in;
   logic [LEFT_BITS-1:0]  left_bits_ff, left_bits_in;
   logic [2:0]            left_cnt_ff, left_cnt_in;
   logic [WIDTH_BITS-1:0] width_eff;
   logic [VALUE_BITS-1:0] code;
   logic [WIDTH_BITS-1:0] total;
   logic [WIDTH_BITS-1:0] sh1;
   logic [WIDTH_BITS-1:0] sh2;
   logic [2:0]            new_cnt;
   logic [LEFT_BITS-1:0]  new_mask;
   logic                  two;
   logic [ACC_BITS-1:0]   acc;
   logic [ACC_BITS-1:0]   acc_hi;
   logic [ACC_BITS-1:0]   acc_lo;

   assign csr_ready = 1'b1;
   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      if (req_code_width < WIDTH_BITS'(MIN_CODE_BITS)) begin
         width_eff = WIDTH_BITS'(MIN_CODE_BITS);
      end else if (req_code_width > WIDTH_BITS'(CODE_BITS_LIM)) begin
         width_eff = WIDTH_BITS'(CODE_BITS_LIM);
      end else begin
         width_eff = req_code_width;
      end
      code     = req_code_value & ~({VALUE_BITS{1'b1}} << width_eff);
      total    = {2'b00, left_cnt_ff} + width_eff;
      two      = total[4];
      new_cnt  = total[2:0];
      new_mask = ~({LEFT_BITS{1'b1}} << new_cnt);
      sh1      = total - WIDTH_BITS'(BYTE_BITS);
      sh2      = total - WIDTH_BITS'(2 * BYTE_BITS);
      if (msb_first_ff) begin
         acc    = ({{VALUE_BITS{1'b0}}, left_bits_ff} << width_eff)
                  | {{LEFT_BITS{1'b0}}, code};
         acc_hi = acc >> sh1;
         acc_lo = acc >> sh2;
         q_pkt.byte0  = acc_hi[BYTE_BITS-1:0];
         q_pkt.byte1  = acc_lo[BYTE_BITS-1:0];
         left_bits_in = acc[LEFT_BITS-1:0] & new_mask;
      end else begin
         acc    = {{VALUE_BITS{1'b0}}, left_bits_ff}
                  | ({{LEFT_BITS{1'b0}}, code} << left_cnt_ff);
         acc_hi = acc;
         acc_lo = acc;
         q_pkt.byte0  = acc_hi[BYTE_BITS-1:0];
         q_pkt.byte1  = acc_lo[2*BYTE_BITS-1:BYTE_BITS];
         left_bits_in = (two ? acc[2*BYTE_BITS+LEFT_BITS-1:2*BYTE_BITS]
                             : acc[BYTE_BITS+LEFT_BITS-1:BYTE_BITS]) & new_mask;
      end
      q_pkt.two    = two;
      left_cnt_in  = new_cnt;
      msb_first_in = (csr_valid && csr_ready) ? csr_msb_first : msb_first_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         msb_first_ff <= 1'b0;
         left_bits_ff <= '0;
         left_cnt_ff  <= '0;
      end else begin
         msb_first_ff <= msb_first_in;
         if (q_push) begin
            left_bits_ff <= left_bits_in;
            left_cnt_ff  <= left_cnt_in;
         end
      end
   end

endmodule

@@ rtl/core/lzwbp_queue.sv @@
// two-entry queue between the front and back parts
// depends on lzwbp_pkg
module lzwbp_queue import lzwbp_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  pkt_type  push_pkt,
   output logic     full,
   input  logic     pop,
   output head_type head
);

   pkt_type    mem_ff [QUEUE_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      full      = (count_ff == 2'(QUEUE_DEPTH));
      head.valid = (count_ff != 2'd0);
      head.pkt   = mem_ff[rd_ptr_ff];
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_pkt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full || pop)
      else $error("queue push while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("queue pop while empty");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'(QUEUE_DEPTH))
      else $error("queue count out of range");
`endif

endmodule

@@ rtl/core/lzwbp_back.sv @@
// back part: sends the one or two bytes of each queued code through the output register
// depends on lzwbp_pkg
module lzwbp_back import lzwbp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  head_type             head,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [BYTE_BITS-1:0] rsp_out_byte,
   output logic                 rsp_last_byte
);

   logic                 phase_ff, phase_in;
   logic                 valid_ff, valid_in;
   logic [BYTE_BITS-1:0] byte_ff, byte_in;
   logic                 last_ff, last_in;
   logic                 out_free;
   logic                 load;
   logic                 is_last;

   always_comb begin
      out_free = !valid_ff || !rsp_stall;
      load     = head.valid && out_free;
      is_last  = phase_ff || !head.pkt.two;
      pop      = load && is_last;
      byte_in  = phase_ff ? head.pkt.byte1 : head.pkt.byte0;
      last_in  = is_last;
      phase_in = load ? !is_last : phase_ff;
      valid_in = load ? 1'b1 : (out_free ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= byte_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_out_byte  = byte_ff;
   assign rsp_last_byte = last_ff;

`ifndef SYNTHESIS
   a_phase_two: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> head.valid && head.pkt.two)
      else $error("second byte pending without a two-byte entry");
   a_second_last: assert property (@(posedge clock) disable iff (reset)
      (phase_ff && out_free) |=> valid_ff && last_ff)
      else $error("second byte not marked last");
   a_first_of_two: assert property (@(posedge clock) disable iff (reset)
      (load && !phase_ff && head.pkt.two) |=> phase_ff && !last_ff)
      else $error("first of two bytes marked last");
`endif

endmodule

@@ rtl/core/lzw_code_bit_packer.sv @@
// lzw code bit packer top level: front, queue and back parts
// depends on lzwbp_pkg, lzwbp_front, lzwbp_queue, lzwbp_back
// path: the first byte of a code is registered in a queue entry and then in the output register before it shows on rsp
// throughput: one code per cycle for one-byte codes while rsp does not stall;
//    the output register sends one byte per cycle, so a two-byte code holds it for both bytes
// reset: synchronous, clears bit order to lsb first, leftover bits and queue
module lzw_code_bit_packer import lzwbp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [VALUE_BITS-1:0] req_code_value,
   input  logic [WIDTH_BITS-1:0] req_code_width,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [BYTE_BITS-1:0]  rsp_out_byte,
   output logic                  rsp_last_byte,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_msb_first
);

   logic     q_full;
   logic     q_push;
   logic     q_pop;
   pkt_type  q_pkt;
   head_type q_head;

   lzwbp_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_code_value (req_code_value),
      .req_code_width (req_code_width),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_msb_first  (csr_msb_first),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_pkt          (q_pkt)
   );

   lzwbp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_pkt (q_pkt),
      .full     (q_full),
      .pop      (q_pop),
      .head     (q_head)
   );

   lzwbp_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (q_head),
      .pop           (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last_byte (rsp_last_byte)
   );

endmodule

@@ dv/testbench.sv @@
// self-checking testbench for lzw_code_bit_packer: random and directed codes in both bit orders
// predicts the packed byte stream per code and checks every rsp transfer in order
// depends on lzwbp_pkg and lzw_code_bit_packer
module testbench import lzwbp_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 80;

   typedef struct packed {
      logic [VALUE_BITS-1:0] value;
      logic [WIDTH_BITS-1:0] width;
   } code_item_type;

   typedef struct packed {
      logic [BYTE_BITS-1:0] out_byte;
      logic                 last_byte;
   } packed_byte_type;

   logic                  clock          = 1'b0;
   logic                  reset          = 1'b1;
   logic                  req_valid      = 1'b0;
   logic                  req_stall;
   logic [VALUE_BITS-1:0] req_code_value = '0;
   logic [WIDTH_BITS-1:0] req_code_width = '0;
   logic                  rsp_valid;
   logic                  rsp_stall      = 1'b0;
   logic [BYTE_BITS-1:0]  rsp_out_byte;
   logic                  rsp_last_byte;
   logic                  csr_valid      = 1'b0;
   logic                  csr_ready;
   logic                  csr_msb_first  = 1'b0;

   code_item_type   code_queue[$];
   packed_byte_type expected_bytes[$];

   logic                 bit_order;
   logic [LEFT_BITS-1:0] pend_bits;
   logic [2:0]           pend_count;

   int unsigned send_idle_pct = 0;
   int unsigned stall_pct     = 0;
   int unsigned hold_req      = 0;
   int unsigned hold_seen;
   int unsigned hold_cnt;
   int unsigned codes_sent    = 0;
   int unsigned bytes_checked = 0;
   int unsigned errors        = 0;
   int unsigned cycles        = 0;
   code_item_type   next_item;
   packed_byte_type got_byte;
   packed_byte_type want_byte;

   lzw_code_bit_packer u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_code_value (req_code_value),
      .req_code_width (req_code_width),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_last_byte  (rsp_last_byte),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_msb_first  (csr_msb_first)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // joins one code to the pending bits and queues the whole bytes it completes
   function automatic void pack_code(input logic [VALUE_BITS-1:0] value,
                                     input logic [WIDTH_BITS-1:0] width);
      int unsigned w;
      int unsigned code;
      int unsigned rem;
      int unsigned total;
      int unsigned nbytes;
      int unsigned newcnt;
      int unsigned acc;
      int unsigned k;
      packed_byte_type b;
      w = 32'(width);
      if (w < MIN_CODE_BITS) w = MIN_CODE_BITS;
      if (w > CODE_BITS_LIM) w = CODE_BITS_LIM;
      code   = 32'(value) & ((32'd1 << w) - 32'd1);
      rem    = 32'(pend_bits) & ((32'd1 << pend_count) - 32'd1);
      total  = 32'(pend_count) + w;
      nbytes = total / BYTE_BITS;
      newcnt = total % BYTE_BITS;
      if (bit_order) begin
         acc = (rem << w) | code;
         for (k = 0; k < nbytes; k++) begin
            b.out_byte  = BYTE_BITS'(acc >> (total - BYTE_BITS * (k + 1)));
            b.last_byte = (k + 1 == nbytes);
            expected_bytes.push_back(b);
         end
         pend_bits = LEFT_BITS'(acc & ((32'd1 << newcnt) - 32'd1));
      end else begin
         acc = rem | (code << pend_count);
         for (k = 0; k < nbytes; k++) begin
            b.out_byte  = BYTE_BITS'(acc >> (BYTE_BITS * k));
            b.last_byte = (k + 1 == nbytes);
            expected_bytes.push_back(b);
         end
         pend_bits = LEFT_BITS'((acc >> (BYTE_BITS * nbytes)) & ((32'd1 << newcnt) - 32'd1));
      end
      pend_count = 3'(newcnt);
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         pend_bits  = '0;
         pend_count = '0;
      end else begin
         if (req_valid && !req_stall) begin
            pack_code(req_code_value, req_code_width);
            codes_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (code_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               next_item = code_queue.pop_front();
               req_valid      <= 1'b1;
               req_code_value <= next_item.value;
               req_code_width <= next_item.width;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall, random, with a long hold-off when the test requests one
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_seen <= 0;
         hold_cnt  <= 0;
      end else if (hold_seen != hold_req) begin
         hold_seen <= hold_req;
         hold_cnt  <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_cnt > 0) begin
         hold_cnt  <= hold_cnt - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         got_byte.out_byte  = rsp_out_byte;
         got_byte.last_byte = rsp_last_byte;
         if (expected_bytes.size() == 0) begin
            $error("byte transfer with nothing expected: out_byte %0h last_byte %0b",
                   got_byte.out_byte, got_byte.last_byte);
            errors++;
         end else begin
            want_byte = expected_bytes.pop_front();
            bytes_checked++;
            if (got_byte.out_byte !== want_byte.out_byte) begin
               $error("out_byte expected %0h actual %0h",
                      want_byte.out_byte, got_byte.out_byte);
               errors++;
            end
            if (got_byte.last_byte !== want_byte.last_byte) begin
               $error("last_byte expected %0b actual %0b",
                      want_byte.last_byte, got_byte.last_byte);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout with %0d bytes outstanding", expected_bytes.size());
         $display("FAIL");
         $finish;
      end
   end

   task automatic wait_drained();
      while (code_queue.size() > 0 || req_valid || expected_bytes.size() > 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_order(input logic msb);
      csr_msb_first <= msb;
      csr_valid     <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      bit_order = msb;
      csr_valid <= 1'b0;
   endtask

   task automatic push_random(input int unsigned n);
      code_item_type item;
      for (int unsigned i = 0; i < n; i++) begin
         if ($urandom_range(99) < 85) item.width = WIDTH_BITS'($urandom_range(16, 9));
         else item.width = WIDTH_BITS'($urandom_range(31, 0));
         item.value = VALUE_BITS'($urandom);
         if ($urandom_range(99) < 70 && item.width >= 9 && item.width <= 16)
            item.value = item.value & VALUE_BITS'((32'd1 << item.width) - 32'd1);
         code_queue.push_back(item);
      end
   endtask

   task automatic run_phase(input int unsigned send_pct, input int unsigned rsp_pct,
                            input logic msb, input int unsigned n);
      wait_drained();
      write_order(msb);
      send_idle_pct = send_pct;
      stall_pct     = rsp_pct;
      push_random(n / 2);
      wait_drained();
      push_random(n - n / 2);
   endtask

   task automatic run_directed(input logic msb);
      logic [VALUE_BITS-1:0] values[12] = '{16'h0000, 16'hffff, 16'hffff, 16'h0000,
                                            16'h01ff, 16'hffff, 16'ha5a5, 16'h5a5a,
                                            16'hffff, 16'h8001, 16'h1234, 16'h03ff};
      logic [WIDTH_BITS-1:0] widths[12] = '{5'd9, 5'd16, 5'd0, 5'd31, 5'd8, 5'd17,
                                            5'd1, 5'd12, 5'd9, 5'd16, 5'd13, 5'd10};
      code_item_type item;
      wait_drained();
      write_order(msb);
      for (int i = 0; i < 12; i++) begin
         item.value = values[i];
         item.width = widths[i];
         code_queue.push_back(item);
      end
   endtask

   initial begin
      bit_order = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed(1'b0);
      run_directed(1'b1);
      run_phase(0, 0, 1'b1, 100);
      run_phase(87, 0, 1'b0, 100);
      run_phase(0, 87, 1'b1, 100);
      run_phase(37, 37, 1'b0, 100);
      // long receiver hold-off while the sender keeps offering codes
      wait_drained();
      write_order(1'b1);
      send_idle_pct = 0;
      stall_pct     = 0;
      push_random(50);
      hold_req++;
      wait_drained();
      repeat (20) @(posedge clock);
      $display("sent %0d codes and checked %0d bytes in both bit orders", codes_sent,
               bytes_checked);
      $display("covered out-of-range widths, excess code bits, idle mixes and a long hold-off");
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

@@ lzw_code_bit_packer.f @@
rtl/core/lzwbp_pkg.sv
rtl/core/lzwbp_front.sv
rtl/core/lzwbp_queue.sv
rtl/core/lzwbp_back.sv
rtl/core/lzw_code_bit_packer.sv
dv/testbench.sv
